// ----- rtl/core/ognw_pkg.sv -----
// Shared types and constants for the occupancy grid neighbour walker.
// Holds the in/out word structs, codes and the neighbour offset table.
// No dependencies; every other file of the block but ognw_ram imports it.
package ognw_pkg;

  localparam int OGNW_MAX_COLS = 64;
  localparam int OGNW_MAX_ROWS = 64;

  // Width of the grid size registers and of internal coordinates.
  localparam int COORD_W   = 7;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int CFG_W     = 7;
  localparam int REG_IDX_W = 1;
  localparam int ID_W      = 12;
  localparam int TOTAL_W   = 2 * COORD_W;
  // A valid id has a quotient below 2^COORD_W, one bit per divider step.
  localparam int DIV_STEPS = COORD_W;

  localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  localparam logic [1:0] KIND_SET_XY = 2'd0;
  localparam logic [1:0] KIND_SET_ID = 2'd1;
  localparam logic [1:0] KIND_QRY_XY = 2'd2;
  localparam logic [1:0] KIND_QRY_ID = 2'd3;

  localparam logic [1:0] OCC_FREE    = 2'd0;
  localparam logic [1:0] OCC_UNKNOWN = 2'd2;

  localparam logic [1:0] OFF_MINUS = 2'd0;
  localparam logic [1:0] OFF_ZERO  = 2'd1;
  localparam logic [1:0] OFF_PLUS  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  cell_col;
    logic [5:0]  cell_row;
    logic [11:0] cell_index;
    logic [1:0]  new_occupancy;
    logic        allow_diagonal;
  } ognw_in_t;

  typedef struct packed {
    logic [5:0]  nbr_col;
    logic [5:0]  nbr_row;
    logic [11:0] nbr_index;
    logic [1:0]  nbr_occupancy;
    logic        found;
    logic        range_error;
    logic        last;
  } ognw_out_t;

  typedef struct packed {
    logic [1:0] dc;
    logic [1:0] dr;
  } ognw_off_t;

  typedef struct packed {
    logic               start;
    logic [ID_W-1:0]    dividend;
    logic [COORD_W-1:0] divisor;
  } ognw_div_req_t;

  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] quot;
    logic [COORD_W-1:0] rem;
  } ognw_div_rsp_t;

  // Walk order: eight-connected goes column outer, row inner, centre skipped;
  // four-connected goes up, down, right, left and uses slots 0 to 3 only.
  function automatic ognw_off_t nbr_offset(input logic diag, input logic [2:0] slot);
    ognw_off_t o;
    o = '{dc: OFF_ZERO, dr: OFF_ZERO};
    if (diag) begin
      unique case (slot)
        3'd0: o = '{dc: OFF_MINUS, dr: OFF_MINUS};
        3'd1: o = '{dc: OFF_MINUS, dr: OFF_ZERO};
        3'd2: o = '{dc: OFF_MINUS, dr: OFF_PLUS};
        3'd3: o = '{dc: OFF_ZERO,  dr: OFF_MINUS};
        3'd4: o = '{dc: OFF_ZERO,  dr: OFF_PLUS};
        3'd5: o = '{dc: OFF_PLUS,  dr: OFF_MINUS};
        3'd6: o = '{dc: OFF_PLUS,  dr: OFF_ZERO};
        3'd7: o = '{dc: OFF_PLUS,  dr: OFF_PLUS};
      endcase
    end else begin
      unique case (slot)
        3'd0:    o = '{dc: OFF_ZERO,  dr: OFF_PLUS};
        3'd1:    o = '{dc: OFF_ZERO,  dr: OFF_MINUS};
        3'd2:    o = '{dc: OFF_PLUS,  dr: OFF_ZERO};
        3'd3:    o = '{dc: OFF_MINUS, dr: OFF_ZERO};
        default: o = '{dc: OFF_ZERO,  dr: OFF_ZERO};
      endcase
    end
    return o;
  endfunction

endpackage

// ----- rtl/core/ognw_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// Standalone; used for the occupancy map.
module ognw_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/ognw_div.sv -----
// Restoring divider that splits a row-major id into row and column.
// Depends on ognw_pkg; one quotient bit per cycle.
module ognw_div
  import ognw_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  ognw_div_req_t req,
  output ognw_div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam int DSH_W = ID_W + 1;

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [ID_W-1:0]    rem_r;
  logic [DSH_W-1:0]   dsh_r;
  logic [COORD_W-1:0] quot_r;
  logic               ge;

  // The quotient is known to fit in DIV_STEPS bits, so the divisor starts
  // shifted up by DIV_STEPS-1 places.
  assign ge = {1'b0, rem_r} >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.dividend;
      dsh_r  <= DSH_W'({req.divisor, {(DIV_STEPS - 1){1'b0}}});
      quot_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r[ID_W-1:0];
      end
      quot_r <= {quot_r[COORD_W-2:0], ge};
      dsh_r  <= dsh_r >> 1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r[COORD_W-1:0];

endmodule

// ----- rtl/core/occupancy_grid_neighbour_walker_core.sv -----
// Top level of the occupancy grid neighbour walker.
// Depends on ognw_pkg, ognw_ram (occupancy map) and ognw_div (id split).
//
// Usage. One input word either writes a cell's occupancy or lists the
// neighbours of a cell; the cell is given by column and row or by row-major
// id. Words enter on in_valid/in_stall and results leave on
// out_valid/out_stall; a word moves at a clock edge with valid high and
// stall low. Writes give no result; a query gives one result word per
// neighbour inside the grid, else one word (flagged if the cell is outside),
// with last on the final one. The grid size registers are written through
// cfg_wen/cfg_index/cfg_wdata by the user while the block is idle, not enforced.
//
// Timing. The block works on one word at a time. A write by coordinate
// passes the execute step only. A query by coordinate passes the execute
// step, which issues the first map read, and then walks the neighbours
// through the single map read port: the walker reads the next neighbour in
// the same cycle that it hands the current one to the output register. An
// id inside the grid first goes through the bit-serial divider that yields
// row and column; an id outside it goes straight on.
//
// Reset. After rst_n the map is cleared one cell a cycle, all 2^(CA+RA) cells
// (4096 at the default 64x64 size); in_stall stays high meanwhile while
// configuration writes are still taken. If the receiver stalls, the result
// word holds in the output register and the walk pauses with the next map
// read held in the RAM's output register.
module occupancy_grid_neighbour_walker_core
  import ognw_pkg::*;
#(
  parameter int MAX_COLS = OGNW_MAX_COLS,
  parameter int MAX_ROWS = OGNW_MAX_ROWS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ognw_in_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ognw_out_t            out_word,
  input  logic                 cfg_wen,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // A coordinate is below both its maximum and 2^COORD_W, so the map address
  // only needs the smaller number of bits.
  localparam int CA      = ($clog2(MAX_COLS) > COORD_W) ? COORD_W : $clog2(MAX_COLS);
  localparam int RA      = ($clog2(MAX_ROWS) > COORD_W) ? COORD_W : $clog2(MAX_ROWS);
  localparam int AW      = CA + RA;
  localparam int DEPTH   = 1 << AW;
  localparam int CLAMP_C = (MAX_COLS > COORD_MAX) ? COORD_MAX : MAX_COLS;
  localparam int CLAMP_R = (MAX_ROWS > COORD_MAX) ? COORD_MAX : MAX_ROWS;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;

  function automatic logic [AW-1:0] map_addr(input logic [COORD_W-1:0] col,
                                             input logic [COORD_W-1:0] row);
    return {row[RA-1:0], col[CA-1:0]};
  endfunction

  function automatic logic [COORD_W-1:0] step_coord(input logic [COORD_W-1:0] v,
                                                    input logic [1:0] off);
    logic [COORD_W-1:0] r;
    r = v;
    if (off == OFF_MINUS) begin
      r = v - COORD_W'(1);
    end else if (off == OFF_PLUS) begin
      r = v + COORD_W'(1);
    end
    return r;
  endfunction

  // Configuration registers and the grid size actually in use.
  logic [CFG_W-1:0]   grid_rows_r;
  logic [CFG_W-1:0]   grid_cols_r;
  logic [COORD_W-1:0] eff_c;
  logic [COORD_W-1:0] eff_r;
  logic [TOTAL_W-1:0] total;

  always_comb begin
    if (grid_cols_r == '0) begin
      eff_c = COORD_W'(1);
    end else if (int'(grid_cols_r) > CLAMP_C) begin
      eff_c = COORD_W'(CLAMP_C);
    end else begin
      eff_c = grid_cols_r;
    end
    if (grid_rows_r == '0) begin
      eff_r = COORD_W'(1);
    end else if (int'(grid_rows_r) > CLAMP_R) begin
      eff_r = COORD_W'(CLAMP_R);
    end else begin
      eff_r = grid_rows_r;
    end
  end

  assign total = TOTAL_W'(eff_c) * TOTAL_W'(eff_r);

  // Sequencer and item registers.
  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  logic               is_query_r;
  logic               diag_r;
  logic               ok_r;
  logic [1:0]         occ_r;
  logic [COORD_W-1:0] col_r;
  logic [COORD_W-1:0] row_r;
  logic [2:0]         rd_slot_r;
  logic [COORD_W-1:0] rd_col_r;
  logic [COORD_W-1:0] rd_row_r;
  logic [AW-1:0]      clr_addr_r;
  logic               out_valid_r;
  ognw_out_t          out_word_r;

  // Decode of the arriving word.
  logic       in_acc;
  logic       in_is_id;
  logic       in_ok_xy;
  logic       in_ok_id;
  logic [1:0] in_occ;

  assign in_acc   = in_valid && !in_stall;
  assign in_is_id = (in_word.kind == KIND_SET_ID) || (in_word.kind == KIND_QRY_ID);
  assign in_ok_xy = ({1'b0, in_word.cell_col} < eff_c) && ({1'b0, in_word.cell_row} < eff_r);
  assign in_ok_id = TOTAL_W'(in_word.cell_index) < total;
  assign in_occ   = (in_word.new_occupancy > OCC_UNKNOWN) ? OCC_UNKNOWN
                                                          : in_word.new_occupancy;

  // Divider for id to (column, row).
  logic          div_start;
  ognw_div_req_t div_req;
  ognw_div_rsp_t div_rsp;

  assign div_req = '{start: div_start, dividend: in_word.cell_index, divisor: eff_c};

  ognw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Which of the eight walk slots land inside the grid, from the edge tests
  // of the centre cell.
  logic       col_lo_ok;
  logic       col_hi_ok;
  logic       row_lo_ok;
  logic       row_hi_ok;
  logic [7:0] nbr_mask;
  logic [7:0] above_mask;
  logic [2:0] first_slot;
  logic [2:0] next_slot;
  logic       more;

  assign col_lo_ok = col_r != '0;
  assign row_lo_ok = row_r != '0;
  assign col_hi_ok = ({1'b0, col_r} + (COORD_W + 1)'(1)) < {1'b0, eff_c};
  assign row_hi_ok = ({1'b0, row_r} + (COORD_W + 1)'(1)) < {1'b0, eff_r};

  always_comb begin
    ognw_off_t o;
    logic      c_ok;
    logic      r_ok;
    for (int s = 0; s < 8; s++) begin
      o    = nbr_offset(diag_r, 3'(s));
      c_ok = (o.dc == OFF_MINUS) ? col_lo_ok : ((o.dc == OFF_PLUS) ? col_hi_ok : 1'b1);
      r_ok = (o.dr == OFF_MINUS) ? row_lo_ok : ((o.dr == OFF_PLUS) ? row_hi_ok : 1'b1);
      nbr_mask[s]   = (diag_r || (s < 4)) && c_ok && r_ok;
      above_mask[s] = nbr_mask[s] && (3'(s) > rd_slot_r);
    end
    first_slot = '0;
    next_slot  = '0;
    for (int s = 7; s >= 0; s--) begin
      if (nbr_mask[s]) begin
        first_slot = 3'(s);
      end
      if (above_mask[s]) begin
        next_slot = 3'(s);
      end
    end
  end

  assign more = |above_mask;

  // Map read for the neighbour that goes out next.
  logic [2:0]         iss_slot;
  ognw_off_t          iss_off;
  logic [COORD_W-1:0] iss_col;
  logic [COORD_W-1:0] iss_row;
  logic [TOTAL_W-1:0] nbr_idx;

  assign iss_slot = (state_r == ST_EXEC) ? first_slot : next_slot;
  assign iss_off  = nbr_offset(diag_r, iss_slot);
  assign iss_col  = step_coord(col_r, iss_off.dc);
  assign iss_row  = step_coord(row_r, iss_off.dr);
  assign nbr_idx  = TOTAL_W'(rd_row_r) * TOTAL_W'(eff_c) + TOTAL_W'(rd_col_r);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [1:0]    ram_wdata;
  logic          rd_en;
  logic [1:0]    ram_rdata;

  // Writes happen only in the clear pass and a write's execute step, reads
  // only as a query starts or walks: no read overlaps a write to its cell.
  ognw_ram #(
    .WIDTH (2),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (map_addr(iss_col, iss_row)),
    .rdata (ram_rdata)
  );

  // The output register can take a word when empty or when it drains now.
  logic      out_free;
  logic      out_load;
  ognw_out_t out_word_nxt;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    ram_we       = 1'b0;
    ram_waddr    = map_addr(col_r, row_r);
    ram_wdata    = occ_r;
    rd_en        = 1'b0;
    out_load     = 1'b0;
    out_word_nxt = '0;
    div_start    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = OCC_FREE;
        if (&clr_addr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_is_id && in_ok_id) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!is_query_r) begin
          ram_we    = ok_r;
          state_nxt = ST_IDLE;
        end else if (!ok_r) begin
          // Queried cell outside the grid: one flagged word.
          if (out_free) begin
            out_load                 = 1'b1;
            out_word_nxt.range_error = 1'b1;
            out_word_nxt.last        = 1'b1;
            state_nxt                = ST_IDLE;
          end
        end else if (nbr_mask == '0) begin
          // Single-cell grid: one word with neither flag set.
          if (out_free) begin
            out_load          = 1'b1;
            out_word_nxt.last = 1'b1;
            state_nxt         = ST_IDLE;
          end
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (out_free) begin
          out_load                   = 1'b1;
          out_word_nxt.nbr_col       = rd_col_r[5:0];
          out_word_nxt.nbr_row       = rd_row_r[5:0];
          out_word_nxt.nbr_index     = nbr_idx[ID_W-1:0];
          out_word_nxt.nbr_occupancy = ram_rdata;
          out_word_nxt.found         = 1'b1;
          out_word_nxt.last          = !more;
          if (more) begin
            rd_en = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      grid_rows_r <= CFG_W'(64);
      grid_cols_r <= CFG_W'(64);
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_GRID_ROWS: grid_rows_r <= cfg_wdata;
          REG_GRID_COLS: grid_cols_r <= cfg_wdata;
        endcase
      end
    end
  end

  // Item and payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      is_query_r <= in_word.kind[1];
      diag_r     <= in_word.allow_diagonal;
      occ_r      <= in_occ;
      ok_r       <= in_is_id ? in_ok_id : in_ok_xy;
      col_r      <= {1'b0, in_word.cell_col};
      row_r      <= {1'b0, in_word.cell_row};
    end else if ((state_r == ST_DIV) && div_rsp.done) begin
      col_r <= div_rsp.rem;
      row_r <= div_rsp.quot;
    end
    if (rd_en) begin
      rd_slot_r <= iss_slot;
      rd_col_r  <= iss_col;
      rd_row_r  <= iss_row;
    end
    if (out_load) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- rtl/core/ognw_checker.sv -----
// Port-level checker for the occupancy grid neighbour walker, with its bind.
// Depends on ognw_pkg and occupancy_grid_neighbour_walker_core.
module ognw_checker
  import ognw_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input ognw_out_t out_word
);

  // The clear pass after reset keeps the input side closed.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // One word at a time: the block is busy right after taking a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again in the cycle after an accept");

  // An out-of-range query ends in its only word and carries no neighbour.
  a_range_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.range_error |-> out_word.last && !out_word.found)
    else $error("range error word is not a lone final word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

endmodule

bind occupancy_grid_neighbour_walker_core ognw_checker u_ognw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ----- bench/ognw_walk_checker.sv -----
// Checker for the occupancy grid neighbour walker: watches both word
// channels and the grid size port, predicts every result word and compares.
// Depends on ognw_pkg for the word structs, codes and register indexes.
`timescale 1ns / 1ps

module ognw_walk_checker
  import ognw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  ognw_in_t             in_word,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  ognw_out_t            out_word,
  input  logic                 cfg_wen,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending,
  output int                   query_count,
  output int                   write_count,
  output int                   word_count
);

  localparam int MAP_CELLS = OGNW_MAX_COLS * OGNW_MAX_ROWS;

  logic [1:0] occ_map [MAP_CELLS];
  int         rows_used;
  int         cols_used;
  ognw_out_t  expected_nbrs [$];
  ognw_out_t  oldest;

  // A size of zero counts as one, anything above the maximum as the maximum.
  function automatic int clamp_size(input logic [CFG_W-1:0] v, input int hi);
    int s;
    s = int'(v);
    if (s < 1) s = 1;
    if (s > hi) s = hi;
    return s;
  endfunction

  function automatic bit on_grid(input int c, input int r);
    return c >= 0 && r >= 0 && c < cols_used && r < rows_used;
  endfunction

  function automatic ognw_out_t make_neighbour(input int c, input int r);
    ognw_out_t o;
    o = '0;
    o.nbr_col       = 6'(c);
    o.nbr_row       = 6'(r);
    o.nbr_index     = 12'(r * cols_used + c);
    o.nbr_occupancy = occ_map[r * OGNW_MAX_COLS + c];
    o.found         = 1'b1;
    return o;
  endfunction

  // Appends one predicted result word behind those already waiting.
  task automatic queue_expected(input ognw_out_t w);
    expected_nbrs.insert(expected_nbrs.size(), w);
  endtask

  task automatic predict_word(input ognw_in_t w);
    int         c;
    int         r;
    int         dc;
    int         dr;
    int         k;
    int         n;
    bit         ok;
    logic [1:0] occ;
    ognw_out_t  walk [8];
    ognw_out_t  flag;
    c = int'(w.cell_col);
    r = int'(w.cell_row);
    n = 0;
    flag = '0;
    occ = (w.new_occupancy > OCC_UNKNOWN) ? OCC_UNKNOWN : w.new_occupancy;
    if (w.kind == KIND_SET_ID || w.kind == KIND_QRY_ID) begin
      ok = int'(w.cell_index) < cols_used * rows_used;
      if (ok) begin
        c = int'(w.cell_index) % cols_used;
        r = int'(w.cell_index) / cols_used;
      end
    end else begin
      ok = on_grid(c, r);
    end

    if (w.kind == KIND_SET_XY || w.kind == KIND_SET_ID) begin
      write_count++;
      if (ok) occ_map[r * OGNW_MAX_COLS + c] = occ;
    end else begin
      query_count++;
      if (!ok) begin
        flag.range_error = 1'b1;
        flag.last        = 1'b1;
        queue_expected(flag);
      end else begin
        if (w.allow_diagonal) begin
          for (dc = -1; dc <= 1; dc++) begin
            for (dr = -1; dr <= 1; dr++) begin
              if ((dc != 0 || dr != 0) && on_grid(c + dc, r + dr)) begin
                walk[n] = make_neighbour(c + dc, r + dr);
                n++;
              end
            end
          end
        end else begin
          // Up, down, right, left.
          for (k = 0; k < 4; k++) begin
            dc = (k == 2) ? 1 : (k == 3) ? -1 : 0;
            dr = (k == 0) ? 1 : (k == 1) ? -1 : 0;
            if (on_grid(c + dc, r + dr)) begin
              walk[n] = make_neighbour(c + dc, r + dr);
              n++;
            end
          end
        end
        if (n == 0) begin
          flag.last = 1'b1;
          queue_expected(flag);
        end else begin
          walk[n - 1].last = 1'b1;
          for (k = 0; k < n; k++) queue_expected(walk[k]);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAP_CELLS; i++) occ_map[i] = OCC_FREE;
      rows_used   = OGNW_MAX_ROWS;
      cols_used   = OGNW_MAX_COLS;
      fail_count  = 0;
      query_count = 0;
      write_count = 0;
      word_count  = 0;
      expected_nbrs.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_nbrs.size() == 0) begin
          $error("result word %h arrived with no result expected", out_word);
          fail_count++;
        end else begin
          oldest = expected_nbrs.pop_front();
          word_count++;
          check_field("nbr_col", int'(oldest.nbr_col), int'(out_word.nbr_col));
          check_field("nbr_row", int'(oldest.nbr_row), int'(out_word.nbr_row));
          check_field("nbr_index", int'(oldest.nbr_index), int'(out_word.nbr_index));
          check_field("nbr_occupancy", int'(oldest.nbr_occupancy),
                      int'(out_word.nbr_occupancy));
          check_field("found", int'(oldest.found), int'(out_word.found));
          check_field("range_error", int'(oldest.range_error),
                      int'(out_word.range_error));
          check_field("last", int'(oldest.last), int'(out_word.last));
        end
      end
      if (cfg_wen) begin
        if (cfg_index == REG_GRID_ROWS) rows_used = clamp_size(cfg_wdata, OGNW_MAX_ROWS);
        else if (cfg_index == REG_GRID_COLS) cols_used = clamp_size(cfg_wdata, OGNW_MAX_COLS);
      end
      if (in_valid && !in_stall) predict_word(in_word);
    end
    pending = expected_nbrs.size();
  end

endmodule

// ----- bench/occupancy_grid_neighbour_walker_core_tb.sv -----
// Top of the occupancy grid neighbour walker testbench: clock, reset,
// stimulus, receiver stalls, watchdog and verdict. Depends on ognw_pkg,
// the block itself and ognw_walk_checker, which does all result checking.
`timescale 1ns / 1ps

module occupancy_grid_neighbour_walker_core_tb;
  import ognw_pkg::*;

  // Cycles without any accepted word or register write before the run is
  // declared hung. It leaves ample room over the clearing pass after reset
  // and the long output hold of a correct run.
  localparam int QUIET_LIMIT      = 20000;
  // Cycles allowed after the last result for a trailing write to retire.
  localparam int SETTLE_CYCLES    = 24;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS      = 70;

  localparam logic [1:0] OCC_TAKEN = 2'd1;
  localparam logic [1:0] OCC_CODE3 = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  ognw_in_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  ognw_out_t            out_word;
  logic                 cfg_wen   = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_GRID_ROWS;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int fail_count;
  int pending;
  int query_count;
  int write_count;
  int word_count;

  // Idling percentages, read by the sender task and the receiver process.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Bumped by the stimulus to ask the receiver for one long hold-off.
  int hold_requests  = 0;
  // Grid size in use, as the block sees it, for shaping random words.
  int rows_now       = OGNW_MAX_ROWS;
  int cols_now       = OGNW_MAX_COLS;
  int grid_settings  = 0;

  always #5 clk = ~clk;

  occupancy_grid_neighbour_walker_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ognw_walk_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .query_count (query_count),
    .write_count (write_count),
    .word_count  (word_count)
  );

  // Receiver. Requests and the stall percentage are picked up at the rising
  // edge, where the stimulus never changes them, and the stall itself is
  // driven at the falling edge. A requested hold-off keeps out_stall high
  // until a countdown kept here runs out.
  initial begin : receiver
    int hold_left;
    int seen;
    int pct;
    hold_left = 0;
    seen      = 0;
    pct       = 0;
    forever begin
      @(posedge clk);
      pct = recv_stall_pct;
      if (hold_requests != seen) begin
        seen      = hold_requests;
        hold_left = LONG_HOLD_CYCLES;
      end
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < pct);
      end
    end
  end

  // Watchdog: any accepted word on either channel, or a register write,
  // restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // Offers one word and returns at the falling edge after it was taken.
  // Idle cycles go in front of the word at random. Valid stays high into the
  // next word when no idle cycle is drawn, so it is never dropped and raised
  // within one time step.
  task automatic send_word(input ognw_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering words until every expected result has come back, then
  // lets a trailing write retire so the block is truly idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes both grid size registers; only called while the block is idle.
  task automatic set_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_GRID_ROWS;
    cfg_wdata <= rows;
    @(negedge clk);
    cfg_index <= REG_GRID_COLS;
    cfg_wdata <= cols;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    rows_now = (rows == 0) ? 1 : (int'(rows) > OGNW_MAX_ROWS) ? OGNW_MAX_ROWS : int'(rows);
    cols_now = (cols == 0) ? 1 : (int'(cols) > OGNW_MAX_COLS) ? OGNW_MAX_COLS : int'(cols);
    grid_settings++;
    @(negedge clk);
  endtask

  // Fields that the kind does not use are filled at random so that their
  // bits toggle as well.
  function automatic ognw_in_t xy_word(input logic [1:0] kind, input int col, input int row,
                                       input logic [1:0] occ, input logic diag);
    ognw_in_t w;
    w.kind           = kind;
    w.cell_col       = 6'(col);
    w.cell_row       = 6'(row);
    w.cell_index     = 12'($urandom_range(4095));
    w.new_occupancy  = occ;
    w.allow_diagonal = diag;
    return w;
  endfunction

  function automatic ognw_in_t id_word(input logic [1:0] kind, input int idx,
                                       input logic [1:0] occ, input logic diag);
    ognw_in_t w;
    w.kind           = kind;
    w.cell_col       = 6'($urandom_range(63));
    w.cell_row       = 6'($urandom_range(63));
    w.cell_index     = 12'(idx);
    w.new_occupancy  = occ;
    w.allow_diagonal = diag;
    return w;
  endfunction

  // Grid sizes lean on the extremes: zero, one, two, the maximum and values
  // above it, with plain random sizes the rest of the time.
  function automatic logic [CFG_W-1:0] pick_size(input int hi);
    case ($urandom_range(7))
      0:       return '0;
      1:       return 7'd1;
      2:       return 7'd2;
      3:       return 7'(hi);
      4:       return 7'($urandom_range(127, hi + 1));
      default: return 7'($urandom_range(hi, 1));
    endcase
  endfunction

  // Most words address a cell inside the grid, often on its far edge, so
  // walks get clipped; one in ten uses the full field range, mostly landing
  // outside. Writes that land outside are ignored and are not counted.
  task automatic make_random_word(output ognw_in_t w, output bit counts);
    int total;
    total            = rows_now * cols_now;
    w.kind           = 2'($urandom_range(3));
    w.new_occupancy  = 2'($urandom_range(3));
    w.allow_diagonal = 1'($urandom_range(1));
    w.cell_col       = 6'($urandom_range(63));
    w.cell_row       = 6'($urandom_range(63));
    w.cell_index     = 12'($urandom_range(4095));
    if ($urandom_range(9) != 0) begin
      w.cell_col   = ($urandom_range(3) == 0) ? 6'(cols_now - 1) : 6'($urandom_range(cols_now - 1));
      w.cell_row   = ($urandom_range(3) == 0) ? 6'(rows_now - 1) : 6'($urandom_range(rows_now - 1));
      w.cell_index = ($urandom_range(5) == 0) ? 12'(total - 1) : 12'($urandom_range(total - 1));
    end
    if (w.kind == KIND_QRY_XY || w.kind == KIND_QRY_ID) counts = 1'b1;
    else if (w.kind == KIND_SET_XY) counts = int'(w.cell_col) < cols_now &&
                                             int'(w.cell_row) < rows_now;
    else counts = int'(w.cell_index) < total;
  endtask

  // One random phase: a fresh grid size, then random words under the given
  // idling mix. Optionally the sender pauses halfway until all results are in.
  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items,
                           input bit pause_midway);
    ognw_in_t w;
    bit       counts;
    int       sent;
    bit       paused;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    set_grid(pick_size(OGNW_MAX_ROWS), pick_size(OGNW_MAX_COLS));
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      make_random_word(w, counts);
      send_word(w);
      if (counts) sent++;
      if (pause_midway && !paused && sent >= n_items / 2) begin
        wait_idle();
        paused = 1'b1;
      end
    end
    wait_idle();
  endtask

  initial begin : stimulus
    ognw_in_t w;
    bit       counts;
    // Reset is held low from time zero, then released at a falling edge.
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words on the default 64x64 grid. The first one waits out the
    // clearing pass that follows reset.
    send_word(xy_word(KIND_SET_XY, 0, 0, OCC_TAKEN, 1'b0));
    send_word(xy_word(KIND_SET_XY, 63, 63, OCC_UNKNOWN, 1'b1));
    // Occupancy code 3 is stored as unknown.
    send_word(xy_word(KIND_SET_XY, 63, 0, OCC_CODE3, 1'b0));
    send_word(id_word(KIND_SET_ID, 4095, OCC_TAKEN, 1'b0));
    send_word(id_word(KIND_SET_ID, 65, OCC_UNKNOWN, 1'b1));
    send_word(xy_word(KIND_QRY_XY, 0, 0, OCC_FREE, 1'b1));
    send_word(xy_word(KIND_QRY_XY, 0, 0, OCC_FREE, 1'b0));
    send_word(xy_word(KIND_QRY_XY, 63, 63, OCC_CODE3, 1'b1));
    send_word(xy_word(KIND_QRY_XY, 1, 0, OCC_FREE, 1'b1));
    send_word(id_word(KIND_QRY_ID, 64, OCC_FREE, 1'b0));
    send_word(id_word(KIND_QRY_ID, 4095, OCC_FREE, 1'b1));
    send_word(xy_word(KIND_QRY_XY, 32, 17, OCC_FREE, 1'b1));
    wait_idle();

    // A 3x5 grid: writes and queries just past the edge, and queries on it, by coordinate and id.
    set_grid(7'd3, 7'd5);
    send_word(xy_word(KIND_SET_XY, 5, 0, OCC_TAKEN, 1'b0));
    send_word(id_word(KIND_SET_ID, 15, OCC_TAKEN, 1'b0));
    send_word(xy_word(KIND_QRY_XY, 0, 3, OCC_FREE, 1'b1));
    send_word(id_word(KIND_QRY_ID, 15, OCC_FREE, 1'b0));
    send_word(id_word(KIND_QRY_ID, 14, OCC_FREE, 1'b1));
    send_word(xy_word(KIND_QRY_XY, 4, 0, OCC_FREE, 1'b0));
    wait_idle();

    // Zero sizes act as a 1x1 grid, where a query finds no neighbour.
    set_grid('0, '0);
    send_word(xy_word(KIND_QRY_XY, 0, 0, OCC_FREE, 1'b1));
    send_word(id_word(KIND_QRY_ID, 0, OCC_FREE, 1'b0));
    send_word(id_word(KIND_SET_ID, 0, OCC_UNKNOWN, 1'b0));
    send_word(id_word(KIND_QRY_ID, 1, OCC_FREE, 1'b1));
    wait_idle();

    // Sizes above the maximum act as the maximum; the map survives resizing.
    set_grid(7'd127, 7'd65);
    send_word(xy_word(KIND_QRY_XY, 63, 63, OCC_FREE, 1'b1));
    send_word(xy_word(KIND_QRY_XY, 1, 1, OCC_FREE, 1'b0));
    wait_idle();

    // Random phases under each idling mix. The last one also pauses the
    // sender halfway until every result has come back.
    run_phase(0, 0, PHASE_ITEMS, 1'b0);
    run_phase(51, 0, PHASE_ITEMS, 1'b0);
    run_phase(0, 51, PHASE_ITEMS, 1'b0);
    run_phase(20, 20, PHASE_ITEMS, 1'b1);

    // Back pressure: the receiver holds off for a long stretch while the
    // sender keeps offering eight-connected queries on the full grid, so the
    // output register fills and the block stalls its input.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_grid(7'(OGNW_MAX_ROWS), 7'(OGNW_MAX_COLS));
    hold_requests++;
    repeat (20) begin
      make_random_word(w, counts);
      w.kind           = KIND_QRY_XY;
      w.allow_diagonal = 1'b1;
      w.cell_col       = 6'($urandom_range(cols_now - 1));
      w.cell_row       = 6'($urandom_range(rows_now - 1));
      send_word(w);
    end
    wait_idle();

    $display("Ran %0d writes and %0d queries over %0d grid sizes; %0d result words checked.",
             write_count, query_count, grid_settings, word_count);
    $display("Idling mixes: none, sender, receiver, both; plus one long output hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
